// ===== design/lwkz_pkg.sv =====
// Shared types and fixed field widths for the longest-window unit.
package lwkz_pkg;

    // Fixed widths of the configuration register and the result fields.
    localparam int CFG_W = 8;
    localparam int OUT_W = 16;

    // Per-item control carried from the front stage to the window stage.
    typedef struct packed {
        logic consumed;   // item advanced the position
        logic popped;     // oldest zeros left the window
        logic last;       // item closes the sequence
    } s2_ctl_t;

endpackage

// ===== design/longest_window_k_zeros_unit.sv =====
// best_start/best_end are loaded into the output register when the item that carries the last bit
// leaves the window stage; that item waits there while the previous result has not been taken.
// Throughput: one item per cycle unless a closing item waits. The zero-position FIFO memory is read
// at acceptance of every item, written per zero; the read completes where the window start moves.
// Reset clears all counters, the window and the best window; the FIFO memory is not cleared
// since only entries written in the current sequence are read. No clearing pass is needed.
module longest_window_k_zeros_unit #(
    parameter int unsigned MAX_LEN         = 65535,
    parameter int unsigned ZERO_FIFO_DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [lwkz_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       bit_value,
    input  logic                       end_of_sequence,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lwkz_pkg::OUT_W-1:0] best_start,
    output logic [lwkz_pkg::OUT_W-1:0] best_end
);

    localparam int PW = $clog2(64'(MAX_LEN) + 64'd1);
    localparam int AW = (ZERO_FIFO_DEPTH > 1) ? $clog2(ZERO_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(64'(ZERO_FIFO_DEPTH) + 64'd1);
    localparam logic [31:0]   LIM_CAP  = 32'(ZERO_FIFO_DEPTH - 1);
    localparam logic [CW:0]   DEPTH_S  = (CW + 1)'(ZERO_FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(ZERO_FIFO_DEPTH - 1);
    localparam logic [PW-1:0] POS_MAX  = PW'(MAX_LEN);

    // Configuration register.
    logic [lwkz_pkg::CFG_W-1:0] max_zeros_reg;

    // Front stage state.
    logic [PW-1:0] position_reg, position_next;
    logic [CW-1:0] zero_count_reg, zero_count_next;
    logic [AW-1:0] fifo_head_reg, fifo_head_next;
    logic [AW-1:0] fifo_tail_reg, fifo_tail_next;

    // Window stage state.
    logic                s2_valid_reg;
    lwkz_pkg::s2_ctl_t   s2_ctl_reg, s2_ctl_next;
    logic [PW-1:0]       s2_pos_reg;
    logic [PW:0]         window_start_reg, window_start_next;
    logic [PW-1:0]       best_length_reg, best_length_next;
    logic [PW:0]         best_left_reg, best_left_next;
    logic [PW-1:0]       best_right_reg, best_right_next;

    // Output register.
    logic                       out_valid_reg;
    logic [lwkz_pkg::OUT_W-1:0] best_start_reg;
    logic [lwkz_pkg::OUT_W-1:0] best_end_reg;

    // Zero-position memory with registered read and same-edge forwarding.
    logic [PW-1:0] zpos_mem [ZERO_FIFO_DEPTH];
    logic [PW-1:0] mem_q_reg;
    logic          fwd_hit_reg;
    logic [PW-1:0] fwd_data_reg;

    logic          in_fire;
    logic          s2_advance;
    logic          out_free;
    logic          consume;
    logic          is_zero;
    logic [CW-1:0] limit;
    logic [CW-1:0] cnt_inc;
    logic          pop;
    logic [CW-1:0] excess;
    logic [CW:0]   head_sum;
    logic [CW:0]   head_mod;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] pos_inc;
    logic [PW-1:0] rd_data;
    logic [PW:0]   ws_eff;
    logic [PW:0]   len_wide;
    logic [PW-1:0] length;

    // Handshake: the window stage holds only when a result cannot be parked.
    assign out_free   = !out_valid_reg || out_ready;
    assign s2_advance = s2_valid_reg && (!s2_ctl_reg.last || out_free);
    assign in_ready   = !s2_valid_reg || s2_advance;
    assign in_fire    = in_valid && in_ready;

    // Effective limit is capped at one below the FIFO depth.
    always_comb
    begin
        if (32'(max_zeros_reg) >= LIM_CAP)
            limit = CW'(LIM_CAP);
        else
            limit = CW'(max_zeros_reg);
    end

    // Front stage: position, zero count and FIFO pointers.
    always_comb
    begin
        consume  = position_reg < POS_MAX;
        is_zero  = consume && !bit_value;
        pos_inc  = position_reg + PW'(1);
        cnt_inc  = zero_count_reg + CW'(is_zero);
        pop      = consume && (cnt_inc > limit);
        excess   = cnt_inc - limit;
        head_sum = (CW + 1)'(fifo_head_reg) + (CW + 1)'(excess);
        if (head_sum >= DEPTH_S)
            head_mod = head_sum - DEPTH_S;
        else
            head_mod = head_sum;
        if (head_mod == '0)
            rd_addr = LAST_IDX;
        else
            rd_addr = AW'(head_mod - (CW + 1)'(1));
        wr_en = in_fire && is_zero;

        position_next   = position_reg;
        zero_count_next = zero_count_reg;
        fifo_head_next  = fifo_head_reg;
        fifo_tail_next  = fifo_tail_reg;
        if (consume)
        begin
            position_next   = pos_inc;
            zero_count_next = pop ? limit : cnt_inc;
            if (pop)
                fifo_head_next = AW'(head_mod);
            if (is_zero)
                fifo_tail_next = (fifo_tail_reg == LAST_IDX) ? '0 : fifo_tail_reg + AW'(1);
        end
        if (end_of_sequence)
        begin
            position_next   = '0;
            zero_count_next = '0;
            fifo_head_next  = '0;
            fifo_tail_next  = '0;
        end

        s2_ctl_next.consumed = consume;
        s2_ctl_next.popped   = pop;
        s2_ctl_next.last     = end_of_sequence;
    end

    // Window stage: move the start, measure the window, keep the best.
    always_comb
    begin
        rd_data  = fwd_hit_reg ? fwd_data_reg : mem_q_reg;
        ws_eff   = s2_ctl_reg.popped ? ((PW + 1)'(rd_data) + (PW + 1)'(1)) : window_start_reg;
        len_wide = (PW + 1)'(s2_pos_reg) + (PW + 1)'(1) - ws_eff;
        length   = PW'(len_wide);

        window_start_next = window_start_reg;
        best_length_next  = best_length_reg;
        best_left_next    = best_left_reg;
        best_right_next   = best_right_reg;
        if (s2_ctl_reg.consumed)
        begin
            window_start_next = ws_eff;
            if (length > best_length_reg)
            begin
                best_length_next = length;
                best_left_next   = ws_eff;
                best_right_next  = s2_pos_reg;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_zeros_reg    <= '0;
            position_reg     <= '0;
            zero_count_reg   <= '0;
            fifo_head_reg    <= '0;
            fifo_tail_reg    <= '0;
            s2_valid_reg     <= 1'b0;
            s2_ctl_reg       <= '0;
            window_start_reg <= (PW + 1)'(1);
            best_length_reg  <= '0;
            best_left_reg    <= '0;
            best_right_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_zeros_reg <= cfg_wr_data;

            if (in_fire)
            begin
                position_reg   <= position_next;
                zero_count_reg <= zero_count_next;
                fifo_head_reg  <= fifo_head_next;
                fifo_tail_reg  <= fifo_tail_next;
                s2_ctl_reg     <= s2_ctl_next;
            end

            if (in_fire)
                s2_valid_reg <= 1'b1;
            else if (s2_advance)
                s2_valid_reg <= 1'b0;

            if (s2_advance)
            begin
                if (s2_ctl_reg.last)
                begin
                    window_start_reg <= (PW + 1)'(1);
                    best_length_reg  <= '0;
                    best_left_reg    <= '0;
                    best_right_reg   <= '0;
                end
                else
                begin
                    window_start_reg <= window_start_next;
                    best_length_reg  <= best_length_next;
                    best_left_reg    <= best_left_next;
                    best_right_reg   <= best_right_next;
                end
            end

            if (s2_advance && s2_ctl_reg.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: item position, result fields, memory and read port.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s2_pos_reg   <= pos_inc;
            mem_q_reg    <= zpos_mem[rd_addr];
            fwd_hit_reg  <= wr_en && (rd_addr == fifo_tail_reg);
            fwd_data_reg <= pos_inc;
        end
        if (wr_en)
            zpos_mem[fifo_tail_reg] <= pos_inc;
        if (s2_advance && s2_ctl_reg.last)
        begin
            best_start_reg <= lwkz_pkg::OUT_W'(best_left_next);
            best_end_reg   <= lwkz_pkg::OUT_W'(best_right_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_start = best_start_reg;
    assign best_end   = best_end_reg;

`ifndef SYNTHESIS
    // The zero count never exceeds one below the FIFO depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        zero_count_reg <= CW'(LIM_CAP))
        else $error("zero count above FIFO capacity");

    // Accepting the last bit returns the front stage to its cleared state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_sequence |=> position_reg == '0 && zero_count_reg == '0)
        else $error("front stage not cleared after end of sequence");

    // A new result only appears after a closing item left the window stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_advance && s2_ctl_reg.last))
        else $error("result without a closing item");

    // The window never starts more than one past the newest position.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_ctl_reg.consumed |->
            ws_eff <= (PW + 1)'(s2_pos_reg) + (PW + 1)'(1))
        else $error("window start beyond current position");
`endif

endmodule

// ===== test/longest_window_k_zeros_unit_tb.sv =====
// Self-checking testbench for the longest-window-with-bounded-zeros unit.
`timescale 1ns / 1ps

module longest_window_k_zeros_unit_tb;

    localparam int          CFG_W       = lwkz_pkg::CFG_W;
    localparam int          OUT_W       = lwkz_pkg::OUT_W;
    localparam int unsigned SEQ_MAX_LEN = 65535;
    localparam int unsigned FIFO_DEPTH  = 256;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          DRAIN_WAIT  = 4;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          DIR_N       = 22;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_ready;
    logic             bit_value;
    logic             end_of_sequence;
    logic             out_valid;
    logic             out_ready;
    logic [OUT_W-1:0] best_start;
    logic [OUT_W-1:0] best_end;

    typedef struct {
        logic [OUT_W-1:0] start_pos;
        logic [OUT_W-1:0] end_pos;
    } window_t;

    typedef struct {
        bit               cfg_en;
        logic [CFG_W-1:0] cfg_val;
        logic             b;
        logic             eos;
        bit               fixed;
        logic [OUT_W-1:0] exp_s;
        logic [OUT_W-1:0] exp_e;
    } stim_row_t;

    // Directed rows: a limit write (if any) happens before the row's item.
    stim_row_t directed_rows [DIR_N] = '{
        // Lone zero right after reset with a zero limit: no window at all.
        '{1'b0, 8'd0,   1'b0, 1'b1, 1'b1, 16'd0, 16'd0},
        // Single one.
        '{1'b0, 8'd0,   1'b1, 1'b1, 1'b1, 16'd1, 16'd1},
        // Run of ones broken by a zero.
        '{1'b0, 8'd0,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b1, 1'b1, 1'b0, 16'd0, 16'd0},
        // All zeros with a zero limit.
        '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b0, 1'b1, 1'b1, 16'd0, 16'd0},
        // Largest limit: the whole sequence fits.
        '{1'b1, 8'd255, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b1, 1'b1, 1'b1, 16'd1, 16'd3},
        // Limit of one, then lowered to zero while the sequence is open.
        '{1'b1, 8'd1,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b1, 8'd0,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b1, 1'b1, 1'b0, 16'd0, 16'd0},
        // Two windows of equal length: the earlier one is kept.
        '{1'b0, 8'd0,   1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{1'b0, 8'd0,   1'b1, 1'b1, 1'b1, 16'd1, 16'd1}
    };

    // Predictor state: the limit register and one sequence's window.
    logic [CFG_W-1:0] zero_limit;
    int unsigned      seq_pos;
    int unsigned      win_start;
    int unsigned      zeros_held;
    logic [15:0]      zero_pos_mem [FIFO_DEPTH];
    logic [7:0]       zq_head;
    logic [7:0]       zq_tail;
    int unsigned      best_len;
    int unsigned      best_lo;
    int unsigned      best_hi;

    window_t expected_windows [$];
    int      mismatch_count;
    int      idle_cycles;
    int      result_stall;
    bit      calm;

    longest_window_k_zeros_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .bit_value       (bit_value),
        .end_of_sequence (end_of_sequence),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .best_start      (best_start),
        .best_end        (best_end)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Clears the window state at the end of a sequence and after reset.
    function automatic void clear_window();
        seq_pos    = 0;
        win_start  = 1;
        zeros_held = 0;
        zq_head    = '0;
        zq_tail    = '0;
        best_len   = 0;
        best_lo    = 0;
        best_hi    = 0;
        for (int i = 0; i < FIFO_DEPTH; i++)
        begin
            zero_pos_mem[i] = '0;
        end
    endfunction

    // Advances the window by one bit; returns 1 with the best window on the last bit.
    function automatic bit advance_window(input logic b, input logic eos,
                                          output window_t win);
        int unsigned lim;
        int unsigned excess;
        int unsigned len;
        logic [7:0]  last_idx;
        lim = (zero_limit > FIFO_DEPTH - 1) ? FIFO_DEPTH - 1 : zero_limit;
        win = '{start_pos: '0, end_pos: '0};
        // Bits past the saturated position leave the window alone.
        if (seq_pos < SEQ_MAX_LEN)
        begin
            seq_pos = seq_pos + 1;
            if (!b)
            begin
                zero_pos_mem[zq_tail] = seq_pos[15:0];
                zq_tail = zq_tail + 8'd1;
                zeros_held = zeros_held + 1;
            end
            // Drop every excess oldest zero in one step.
            if (zeros_held > lim)
            begin
                excess     = zeros_held - lim;
                last_idx   = 8'(zq_head + excess - 1);
                win_start  = zero_pos_mem[last_idx] + 1;
                zq_head    = 8'(zq_head + excess);
                zeros_held = lim;
            end
            len = seq_pos + 1 - win_start;
            if (len > best_len)
            begin
                best_len = len;
                best_lo  = win_start;
                best_hi  = seq_pos;
            end
        end
        if (!eos)
        begin
            return 1'b0;
        end
        if (best_len != 0)
        begin
            win.start_pos = best_lo[15:0];
            win.end_pos   = best_hi[15:0];
        end
        clear_window();
        return 1'b1;
    endfunction

    // Offers one item after a random gap and records its expected result.
    task automatic send_item(input logic b, input logic eos, input bit fixed,
                             input logic [OUT_W-1:0] fs, input logic [OUT_W-1:0] fe);
        int      gap;
        bit      has_result;
        window_t win;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        = 1'b1;
        bit_value       = b;
        end_of_sequence = eos;
        do
            @(posedge clk);
        while (!in_ready);
        has_result = advance_window(b, eos, win);
        if (has_result)
        begin
            if (fixed)
            begin
                win = '{start_pos: fs, end_pos: fe};
            end
            expected_windows = {expected_windows, win};
        end
        @(negedge clk);
    endtask

    // Waits until the block has nothing in flight.
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (expected_windows.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Writes the zero limit once the block is quiet.
    task automatic set_zero_limit(input logic [CFG_W-1:0] value);
        wait_quiet();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        zero_limit  = value;
    endtask

    // Result-side stall: the count is drawn anew after every accepted result.
    always @(negedge clk)
    begin
        if (result_stall > 0 && !calm)
        begin
            out_ready    = 1'b0;
            result_stall = result_stall - 1;
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected window.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            result_stall = $urandom_range(0, 5);
            if (expected_windows.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result start=%0d end=%0d",
                             best_start, best_end);
            end
            else
            begin
                window_t want;
                want = expected_windows.pop_front();
                if (best_start !== want.start_pos || best_end !== want.end_pos)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: window start exp=%0d act=%0d, end exp=%0d act=%0d",
                                 want.start_pos, best_start, want.end_pos, best_end);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int random_sent;
        int n_seq;
        int seq_len;
        int zero_pct;
        bit leave_open;
        bit noisy;
        logic b;
        logic eos;

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_valid        = 1'b0;
        bit_value       = 1'b0;
        end_of_sequence = 1'b0;
        out_ready       = 1'b0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        result_stall    = 0;
        calm            = 1'b0;
        zero_limit      = '0;
        clear_window();

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        for (int r = 0; r < DIR_N; r++)
        begin
            if (directed_rows[r].cfg_en)
                set_zero_limit(directed_rows[r].cfg_val);
            send_item(directed_rows[r].b, directed_rows[r].eos, directed_rows[r].fixed,
                      directed_rows[r].exp_s, directed_rows[r].exp_e);
        end

        // Random phases: new limit, then a few sequences, the last sometimes left open.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       set_zero_limit(8'd255);
                1:       set_zero_limit(8'd0);
                2:       set_zero_limit(CFG_W'($urandom_range(0, 255)));
                default: set_zero_limit(CFG_W'($urandom_range(0, 8)));
            endcase
            calm  = ($urandom_range(0, 5) == 0);
            n_seq = $urandom_range(1, 6);
            for (int s = 0; s < n_seq; s++)
            begin
                seq_len    = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 40);
                zero_pct   = $urandom_range(0, 100);
                leave_open = (s == n_seq - 1) && ($urandom_range(0, 3) == 0);
                noisy      = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < seq_len; i++)
                begin
                    b = ($urandom_range(0, 99) >= zero_pct);
                    if (noisy)
                        eos = ($urandom_range(0, 7) == 0);
                    else
                        eos = (i == seq_len - 1) && !leave_open;
                    send_item(b, eos, 1'b0, '0, '0);
                    random_sent++;
                end
            end
        end

        // Many zeros under the largest limit, so the zero FIFO wraps.
        set_zero_limit(8'd255);
        calm = 1'b0;
        for (int i = 0; i < 700; i++)
        begin
            send_item($urandom_range(0, 99) >= 50, i == 699, 1'b0, '0, '0);
        end

        // Drain and finish.
        wait_quiet();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && expected_windows.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/lwkz_pkg.sv
design/longest_window_k_zeros_unit.sv
test/longest_window_k_zeros_unit_tb.sv
